>>> hdl/bse_pkg.sv
// Package for the bubble sort engine: sizes, controller states and the
// memory request struct. No dependencies.
package bse_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    // Controller states, one-hot.
    typedef enum logic [6:0] {
        ST_LOAD    = 7'b0000001,
        ST_RD0     = 7'b0000010,
        ST_FIRST   = 7'b0000100,
        ST_RUN     = 7'b0001000,
        ST_TAIL    = 7'b0010000,
        ST_EMIT_RD = 7'b0100000,
        ST_EMIT_LD = 7'b1000000
    } t_state;

    typedef struct packed {
        logic                     we;
        logic [IDX_W-1:0]         waddr;
        logic signed [DATA_W-1:0] wdata;
        logic                     re;
        logic [IDX_W-1:0]         raddr;
    } t_mem_req;

endpackage

>>> hdl/bse_if.sv
// Valid/ready channel interfaces for the bubble sort engine.
// Depends on bse_pkg for the data width.
interface bse_in_if
    import bse_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value;
    logic                     last_in;

    modport source (output valid, output value, output last_in, input ready);
    modport sink   (input valid, input value, input last_in, output ready);
endinterface

interface bse_out_if
    import bse_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;
    logic                     overflow;

    modport source (output valid, output sorted_value, output last_out, output overflow,
                    input ready);
    modport sink   (input valid, input sorted_value, input last_out, input overflow,
                    output ready);
endinterface

>>> hdl/bse_store.sv
// Element store: one write port, one read port, registered read data.
// Depends on bse_pkg.
module bse_store
    import bse_pkg::*;
(
    input  logic                     i_clk,
    input  t_mem_req                 i_req,
    output logic signed [DATA_W-1:0] o_rdata
);

    logic signed [DATA_W-1:0] r_mem [MAX_ITEMS];
    logic signed [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/bubble_sort_engine_core.sv
// Bubble sort engine top level: load, bubble passes and emission over one
// element store. Depends on bse_pkg, bse_if.sv and bse_store.
//
//  channel  dir  modport  payload
//  i_in     in   sink     value[31:0] signed, last_in
//  o_out    out  source   sorted_value[31:0] signed, last_out, overflow
//
// Loading accepts one transaction per cycle. On a last_in transaction the set
// of n elements is sorted in passes (read of entry 0, a prime step, one
// compare/write per further entry, a tail write); up to n passes run, the last
// finding no swap. Each result takes a store read (ST_EMIT_RD) and a register
// load (ST_EMIT_LD). Reset (i_rst_n low, synchronous) empties the set; store
// contents are left alone. A stalled o_out holds its register; i_in is taken
// again once the final result sits in that register.
module bubble_sort_engine_core
    import bse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    bse_in_if.sink     i_in,
    bse_out_if.source  o_out
);

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic                     r_drop, n_drop;
    logic [IDX_W-1:0]         r_idx, n_idx;      // pass position / emit pointer
    logic signed [DATA_W-1:0] r_hold, n_hold;    // element being bubbled
    logic                     r_swapped, n_swapped;

    logic                     r_ov, n_ov;
    logic signed [DATA_W-1:0] r_odata, n_odata;
    logic                     r_olast, n_olast;
    logic                     r_oflow, n_oflow;

    t_mem_req                 mem_req;
    logic signed [DATA_W-1:0] mem_rdata;
    logic [IDX_W-1:0]         last_idx;
    logic                     in_acc;
    logic                     out_load;

    bse_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    assign last_idx = IDX_W'(r_count - CNT_W'(1));
    assign in_acc   = i_in.valid && i_in.ready;
    assign out_load = (r_state == ST_EMIT_LD) && (!r_ov || o_out.ready);

    assign i_in.ready         = (r_state == ST_LOAD);
    assign o_out.valid        = r_ov;
    assign o_out.sorted_value = r_odata;
    assign o_out.last_out     = r_olast;
    assign o_out.overflow     = r_oflow;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_drop    = r_drop;
        n_idx     = r_idx;
        n_hold    = r_hold;
        n_swapped = r_swapped;
        n_ov      = r_ov && !o_out.ready;
        n_odata   = r_odata;
        n_olast   = r_olast;
        n_oflow   = r_oflow;
        mem_req   = '0;

        unique case (r_state)
            ST_LOAD: begin
                if (in_acc) begin
                    if (r_count < CNT_W'(MAX_ITEMS)) begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = r_count[IDX_W-1:0];
                        mem_req.wdata = i_in.value;
                        n_count       = r_count + CNT_W'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_in.last_in) begin
                        n_state = ST_RD0;
                    end
                end
            end
            ST_RD0: begin
                // start a pass: fetch entry 0
                mem_req.re    = 1'b1;
                mem_req.raddr = '0;
                n_idx         = IDX_W'(1);
                n_swapped     = 1'b0;
                n_state       = ST_FIRST;
            end
            ST_FIRST: begin
                n_hold = mem_rdata;
                if (r_count == CNT_W'(1)) begin
                    n_state = ST_TAIL;
                end else begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = r_idx;
                    n_state       = ST_RUN;
                end
            end
            ST_RUN: begin
                // rdata is entry r_idx; settle entry r_idx-1.
                // Writes trail reads by two entries, so no overlap.
                mem_req.we    = 1'b1;
                mem_req.waddr = r_idx - IDX_W'(1);
                if (r_hold > mem_rdata) begin
                    mem_req.wdata = mem_rdata;
                    n_swapped     = 1'b1;
                end else begin
                    mem_req.wdata = r_hold;
                    n_hold        = mem_rdata;
                end
                if (r_idx == last_idx) begin
                    n_state = ST_TAIL;
                end else begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = r_idx + IDX_W'(1);
                    n_idx         = r_idx + IDX_W'(1);
                end
            end
            ST_TAIL: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = last_idx;
                mem_req.wdata = r_hold;
                if (r_swapped) begin
                    n_state = ST_RD0;
                end else begin
                    n_idx   = '0;
                    n_state = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: begin
                mem_req.re    = 1'b1;
                mem_req.raddr = r_idx;
                n_state       = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (out_load) begin
                    n_ov    = 1'b1;
                    n_odata = mem_rdata;
                    n_olast = (r_idx == last_idx);
                    n_oflow = r_drop;
                    if (r_idx == last_idx) begin
                        n_count = '0;
                        n_drop  = 1'b0;
                        n_state = ST_LOAD;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_count   <= '0;
            r_drop    <= 1'b0;
            r_swapped <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_drop    <= n_drop;
            r_swapped <= n_swapped;
            r_ov      <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_hold  <= n_hold;
        r_odata <= n_odata;
        r_olast <= n_olast;
        r_oflow <= n_oflow;
    end

    // no store writes while results are being read out
    a_no_write_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT_RD || r_state == ST_EMIT_LD) |-> !mem_req.we)
        else $error("store written during emission");

    // pass position never reaches past the stored elements
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN || r_state == ST_EMIT_LD) |->
            (CNT_W'(r_idx) < r_count))
        else $error("index beyond element count");

    // final result loaded: set emptied and loading resumes
    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_idx == last_idx) |=>
            (r_state == ST_LOAD && r_count == '0 && !r_drop && o_out.last_out))
        else $error("set not closed after final result");

    // a sorting set never starts empty
    a_nonempty_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD0) |-> (r_count != '0 && r_count <= CNT_W'(MAX_ITEMS)))
        else $error("sort started with bad element count");

endmodule
